### rtl/rcf_pkg.sv
// Package for the RTMP chunk framer: beat types, header constants and the
// internal run-load struct. No dependencies.
package rcf_pkg;

	localparam int RUN_MAX = 19;
	localparam int RUN_BITS = RUN_MAX * 8;
	localparam int RUN_LEN_W = $clog2(RUN_MAX + 1);

	localparam logic [31:0] TS_SAT = 32'h00FF_FFFF;
	localparam logic [16:0] TWO_BYTE_MIN = 17'd64;
	localparam logic [16:0] THREE_BYTE_ABOVE = 17'd319;
	localparam logic [1:0] FMT_FULL = 2'd0;
	localparam logic [1:0] FMT_CONT = 2'd3;
	localparam logic [16:0] CHUNK_SIZE_RST = 17'd128;
	localparam logic REG_OUT_CHUNK_SIZE = 1'b0;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic        first_of_message;
		logic [16:0] chunk_stream_id;
		logic [23:0] message_length;
		logic [7:0]  type_id;
		logic [31:0] message_stream_id;
		logic [31:0] timestamp;
		logic [31:0] extended_timestamp;
	} pay_beat_t;

	typedef struct packed {
		logic [7:0] wire_byte;
		logic       last_of_run;
		logic       end_of_message;
	} wire_beat_t;

	typedef struct packed {
		logic                 valid;
		logic [RUN_BITS-1:0]  bytes;
		logic [RUN_LEN_W-1:0] len;
		logic                 eom;
	} run_load_t;

endpackage

### rtl/rcf_core.sv
// Framing core: holds message state and builds the whole byte run of one
// payload beat in one pass. Depends on rcf_pkg.
module rcf_core import rcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  pay_beat_t   pay_data,
	input  logic [16:0] chunk_size,
	output run_load_t   load
);

	logic [23:0] remaining_q;
	logic [16:0] fill_q;
	logic [16:0] held_csid_q;
	logic        ext_use_q;
	logic [31:0] held_ext_q;

	logic        first;
	logic        open_msg;
	logic        cont_hdr;
	logic [16:0] csid;
	logic [1:0]  fmt;
	logic [16:0] off17;
	logic [15:0] off;
	logic [1:0]  basic_len;
	logic [23:0] basic3;
	logic        ext_now;
	logic [31:0] ext_val;
	logic [23:0] ts24;
	logic [87:0] mhdr;
	logic [127:0] tail_full;
	logic [39:0]  tail_cont;
	logic [RUN_BITS-1:0] run;
	logic [RUN_LEN_W-1:0] run_len;
	logic [23:0] rem_start;
	logic [23:0] rem_next;
	logic [16:0] fill_start;

	always_comb begin
		first    = pay_data.first_of_message;
		open_msg = (remaining_q != 24'd0);
		cont_hdr = !first && (fill_q >= chunk_size);
		csid     = first ? pay_data.chunk_stream_id : held_csid_q;
		fmt      = first ? FMT_FULL : FMT_CONT;
		off17    = csid - TWO_BYTE_MIN;
		off      = off17[15:0];
		if (csid > THREE_BYTE_ABOVE) begin
			basic_len = 2'd3;
			basic3    = {fmt, 6'd1, off[7:0], off[15:8]};
		end else if (csid >= TWO_BYTE_MIN) begin
			basic_len = 2'd2;
			basic3    = {fmt, 6'd0, off[7:0], 8'h00};
		end else begin
			basic_len = 2'd1;
			basic3    = {fmt, csid[5:0], 16'h0000};
		end

		ext_now = first ? (pay_data.timestamp >= TS_SAT) : ext_use_q;
		ext_val = first ? pay_data.extended_timestamp : held_ext_q;
		ts24    = (pay_data.timestamp >= TS_SAT) ? TS_SAT[23:0] : pay_data.timestamp[23:0];
		mhdr    = {ts24, pay_data.message_length, pay_data.type_id,
			pay_data.message_stream_id[7:0], pay_data.message_stream_id[15:8],
			pay_data.message_stream_id[23:16], pay_data.message_stream_id[31:24]};
		tail_full = ext_now ? {mhdr, ext_val, pay_data.payload_byte}
			: {mhdr, pay_data.payload_byte, 32'h0};
		tail_cont = ext_now ? {ext_val, pay_data.payload_byte}
			: {pay_data.payload_byte, 32'h0};

		// Place the basic header first, then the rest of the run after it.
		if (first) begin
			case (basic_len)
				2'd3:    run = {basic3, tail_full};
				2'd2:    run = {basic3[23:8], tail_full, 8'h00};
				default: run = {basic3[23:16], tail_full, 16'h0000};
			endcase
			run_len = RUN_LEN_W'(basic_len) + RUN_LEN_W'(12)
				+ (ext_now ? RUN_LEN_W'(4) : RUN_LEN_W'(0));
		end else if (cont_hdr) begin
			case (basic_len)
				2'd3:    run = {basic3, tail_cont, 88'h0};
				2'd2:    run = {basic3[23:8], tail_cont, 96'h0};
				default: run = {basic3[23:16], tail_cont, 104'h0};
			endcase
			run_len = RUN_LEN_W'(basic_len) + RUN_LEN_W'(1)
				+ (ext_now ? RUN_LEN_W'(4) : RUN_LEN_W'(0));
		end else begin
			run     = {pay_data.payload_byte, 144'h0};
			run_len = RUN_LEN_W'(1);
		end

		rem_start  = first ? pay_data.message_length : remaining_q;
		rem_next   = (rem_start != 24'd0) ? rem_start - 24'd1 : 24'd0;
		fill_start = (first || cont_hdr) ? 17'd0 : fill_q;

		load.valid = accept && (first || open_msg);
		load.bytes = run;
		load.len   = run_len;
		load.eom   = (rem_next == 24'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			fill_q      <= '0;
			held_csid_q <= '0;
			ext_use_q   <= 1'b0;
			held_ext_q  <= '0;
		end else if (load.valid) begin
			remaining_q <= rem_next;
			fill_q      <= fill_start + 17'd1;
			if (first) begin
				held_csid_q <= pay_data.chunk_stream_id;
				ext_use_q   <= ext_now;
				held_ext_q  <= pay_data.extended_timestamp;
			end
		end
	end

endmodule

### rtl/rcf_run_buf.sv
// Run buffer and wire output register: shifts a loaded byte run out one
// byte per beat. Depends on rcf_pkg.
module rcf_run_buf import rcf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  run_load_t  load,
	output logic       free,
	output logic       wire_valid,
	input  logic       wire_stall,
	output wire_beat_t wire_data
);

	logic [RUN_BITS-1:0]  bytes_q;
	logic [RUN_LEN_W-1:0] cnt_q;
	logic                 eom_q;
	logic                 wire_valid_q;
	wire_beat_t           wire_data_q;
	logic                 advance;
	logic                 last;

	assign advance    = (cnt_q != '0) && (!wire_valid_q || !wire_stall);
	assign last       = (cnt_q == RUN_LEN_W'(1));
	assign free       = (cnt_q == '0) || (advance && last);
	assign wire_valid = wire_valid_q;
	assign wire_data  = wire_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			wire_valid_q <= 1'b0;
		end else begin
			if (load.valid) begin
				cnt_q <= load.len;
			end else if (advance) begin
				cnt_q <= cnt_q - RUN_LEN_W'(1);
			end
			if (advance) begin
				wire_valid_q <= 1'b1;
			end else if (!wire_stall) begin
				wire_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load.valid) begin
			bytes_q <= load.bytes;
			eom_q   <= load.eom;
		end else if (advance) begin
			bytes_q <= {bytes_q[RUN_BITS-9:0], 8'h00};
		end
		if (advance) begin
			wire_data_q.wire_byte      <= bytes_q[RUN_BITS-1 -: 8];
			wire_data_q.last_of_run    <= last;
			wire_data_q.end_of_message <= last && eom_q;
		end
	end

endmodule

### rtl/rtmp_chunk_framer.sv
// RTMP chunk framer top level: configuration register, framing core and
// run buffer. Depends on rcf_pkg, rcf_core and rcf_run_buf.
//
// Usage:
//  - pay channel (pay_valid/pay_stall/pay_data) takes one message payload
//    byte per beat; header fields are sampled on the beat marked
//    first_of_message.
//  - wire channel (wire_valid/wire_stall/wire_data) gives the chunk stream
//    one byte per beat; last_of_run closes the bytes of one pay beat.
//  - Each pay beat makes a run of 1 to 19 wire bytes: a plain payload byte
//    is 1, a chunk boundary adds a fmt-3 header (1-3 bytes plus 4 for an
//    extended timestamp), a message start adds the full fmt-0 header.
//    A byte with no message open is taken and dropped, with no run.
//  - A pay beat loads its run into the run buffer at the edge that takes it;
//    the run's first wire byte then moves out through the wire output register.
//  - Throughput: one wire byte per cycle while wire_stall is low, set by
//    the run buffer shift; a pay beat is taken in the cycle the previous
//    run's last byte moves out, so plain payload bytes stream at one per cycle.
//  - Stall on wire_stall: hold the output byte and the run; pay_stall rises
//    once a run waits in the buffer.
//  - Reset clears all message state and sets out_chunk_size to 128.
//  - out_chunk_size lives at APB byte address 0; write it only while idle.
module rtmp_chunk_framer import rcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pay_valid,
	output logic        pay_stall,
	input  pay_beat_t   pay_data,
	output logic        wire_valid,
	input  logic        wire_stall,
	output wire_beat_t  wire_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [16:0] chunk_size_q;
	logic        free;
	logic        accept;
	run_load_t   load;

	// Register write completes in the access phase; pready is always high.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q <= CHUNK_SIZE_RST;
		end else if (psel && penable && pwrite && (paddr[2] == REG_OUT_CHUNK_SIZE)) begin
			chunk_size_q <= pwdata[16:0];
		end
	end

	assign prdata = (paddr[2] == REG_OUT_CHUNK_SIZE) ? {15'h0, chunk_size_q} : 32'h0;

	// Take a pay beat whenever the run buffer empties this cycle.
	assign pay_stall = !free;
	assign accept    = pay_valid && free;

	rcf_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.pay_data   (pay_data),
		.chunk_size (chunk_size_q),
		.load       (load)
	);

	rcf_run_buf u_run_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.free       (free),
		.wire_valid (wire_valid),
		.wire_stall (wire_stall),
		.wire_data  (wire_data)
	);

endmodule

### dv/rcf_frame_checker.sv
// Checker for the RTMP chunk framer: watches the pay, wire and APB ports, predicts
// every wire beat from the accepted pay beats, and compares in order.
// Depends on rcf_pkg.
module rcf_frame_checker import rcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pay_valid,
	input  logic        pay_stall,
	input  pay_beat_t   pay_data,
	input  logic        wire_valid,
	input  logic        wire_stall,
	input  wire_beat_t  wire_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        drained,
	output int          fails,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [5:0] ID_TWO_BYTE = 6'd0;
	localparam logic [5:0] ID_THREE_BYTE = 6'd1;

	logic [16:0] chunk_size;
	logic [23:0] left_bytes;
	logic [16:0] fill;
	logic [16:0] held_csid;
	logic        ext_on;
	logic [31:0] held_ext;
	wire_beat_t  wire_expect[$];
	int          wire_count;
	bit          leftover_checked;

	task automatic note_mismatch(input string what);
		$display("[%0t] rcf_frame_checker: %s", $time, what);
		fails++;
	endtask

	task automatic push_wire(input logic [7:0] val, input logic eom);
		wire_beat_t w;
		w.wire_byte = val;
		w.last_of_run = 1'b0;
		w.end_of_message = eom;
		wire_expect.push_back(w);
	endtask

	task automatic push_basic(input logic [1:0] fmt, input logic [16:0] csid);
		logic [7:0]  head;
		logic [16:0] off;
		head = {fmt, 6'd0};
		off = csid - TWO_BYTE_MIN;
		if (csid > THREE_BYTE_ABOVE) begin
			push_wire(head | {2'b00, ID_THREE_BYTE}, 1'b0);
			push_wire(off[7:0], 1'b0);
			push_wire(off[15:8], 1'b0);
		end else if (csid >= TWO_BYTE_MIN) begin
			push_wire(head | {2'b00, ID_TWO_BYTE}, 1'b0);
			push_wire(off[7:0], 1'b0);
		end else begin
			// ids 0 and 1 go out as is, colliding with the escapes
			push_wire(head | {2'b00, csid[5:0]}, 1'b0);
		end
	endtask

	task automatic push_be32(input logic [31:0] v);
		push_wire(v[31:24], 1'b0);
		push_wire(v[23:16], 1'b0);
		push_wire(v[15:8], 1'b0);
		push_wire(v[7:0], 1'b0);
	endtask

	// Work out the run of wire beats that one pay beat causes.
	task automatic frame_beat(input pay_beat_t b);
		logic [23:0] ts24;
		wire_beat_t  tail;
		if (b.first_of_message) begin
			ts24 = (b.timestamp < TS_SAT) ? b.timestamp[23:0] : TS_SAT[23:0];
			held_csid = b.chunk_stream_id;
			ext_on = b.timestamp >= TS_SAT;
			held_ext = b.extended_timestamp;
			left_bytes = b.message_length;
			fill = '0;
			push_basic(FMT_FULL, b.chunk_stream_id);
			push_wire(ts24[23:16], 1'b0);
			push_wire(ts24[15:8], 1'b0);
			push_wire(ts24[7:0], 1'b0);
			push_wire(b.message_length[23:16], 1'b0);
			push_wire(b.message_length[15:8], 1'b0);
			push_wire(b.message_length[7:0], 1'b0);
			push_wire(b.type_id, 1'b0);
			push_wire(b.message_stream_id[7:0], 1'b0);
			push_wire(b.message_stream_id[15:8], 1'b0);
			push_wire(b.message_stream_id[23:16], 1'b0);
			push_wire(b.message_stream_id[31:24], 1'b0);
			if (ext_on)
				push_be32(held_ext);
		end else begin
			if (left_bytes == '0)
				return;
			if (fill >= chunk_size) begin
				push_basic(FMT_CONT, held_csid);
				if (ext_on)
					push_be32(held_ext);
				fill = '0;
			end
		end
		if (left_bytes != '0)
			left_bytes = left_bytes - 24'd1;
		fill = fill + 17'd1;
		push_wire(b.payload_byte, left_bytes == '0);
		tail = wire_expect.pop_back();
		tail.last_of_run = 1'b1;
		wire_expect.push_back(tail);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		wire_beat_t want;
		if (!arst_n) begin
			chunk_size = CHUNK_SIZE_RST;
			left_bytes = '0;
			fill = '0;
			held_csid = '0;
			ext_on = 1'b0;
			held_ext = '0;
			wire_expect.delete();
			wire_count = 0;
			leftover_checked = 1'b0;
			fails = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_OUT_CHUNK_SIZE, 2'b00})
				chunk_size = pwdata[16:0];
			if (pay_valid && !pay_stall)
				frame_beat(pay_data);
			if (wire_valid && !wire_stall) begin
				if (wire_expect.size() == 0) begin
					note_mismatch($sformatf("wire beat %0d not expected: %h",
						wire_count, wire_data));
				end else begin
					want = wire_expect.pop_front();
					if (wire_data.wire_byte !== want.wire_byte)
						note_mismatch($sformatf("wire beat %0d: wire_byte %h, want %h",
							wire_count, wire_data.wire_byte, want.wire_byte));
					if (wire_data.last_of_run !== want.last_of_run)
						note_mismatch($sformatf("wire beat %0d: last_of_run %b, want %b",
							wire_count, wire_data.last_of_run, want.last_of_run));
					if (wire_data.end_of_message !== want.end_of_message)
						note_mismatch($sformatf("wire beat %0d: end_of_message %b, want %b",
							wire_count, wire_data.end_of_message, want.end_of_message));
				end
				wire_count++;
			end
			if (drained && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (wire_expect.size() != 0)
					note_mismatch($sformatf("%0d wire beats never arrived",
						wire_expect.size()));
			end
		end
		pending = wire_expect.size();
	end

endmodule

### dv/tb_rtmp_chunk_framer.sv
// Testbench top for the RTMP chunk framer: clock, reset, pay and APB stimulus,
// wire-side stall pattern and the verdict. Depends on rcf_pkg, rtmp_chunk_framer
// and rcf_frame_checker.
module tb_rtmp_chunk_framer;
	import rcf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD = 300;
	localparam int DRAIN_WAIT = 8;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        pay_valid;
	logic        pay_stall;
	pay_beat_t   pay_data;
	logic        wire_valid;
	logic        wire_stall;
	wire_beat_t  wire_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        drained;
	int          fails;
	int          pending;

	// Shared between the pay driver and the wire-side stall process.
	bit jitter;
	bit hold_long;
	// Payload beats still owed by the open message, and beats counted so far.
	int msg_left;
	int items;

	rtmp_chunk_framer dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.pay_valid  (pay_valid),
		.pay_stall  (pay_stall),
		.pay_data   (pay_data),
		.wire_valid (wire_valid),
		.wire_stall (wire_stall),
		.wire_data  (wire_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	rcf_frame_checker frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.pay_valid  (pay_valid),
		.pay_stall  (pay_stall),
		.pay_data   (pay_data),
		.wire_valid (wire_valid),
		.wire_stall (wire_stall),
		.wire_data  (wire_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.drained    (drained),
		.fails      (fails),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Give up long after the slowest legal run would have finished.
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** rtmp_chunk_framer: FAILED **");
		$finish;
	end

	// Wire side: short random stall bursts while jitter is on, and one long
	// hold-off on request so the run buffer fills and pay_stall rises.
	initial begin : wire_side
		wire_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_long) begin
				wire_stall <= 1'b1;
				for (int c = 0; c < LONG_HOLD; c++)
					@(posedge clk);
				hold_long = 1'b0;
				wire_stall <= 1'b0;
			end else if (jitter && $urandom_range(0, 5) == 0) begin
				wire_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				wire_stall <= 1'b0;
			end
		end
	end

	// Continuation beat: header fields are junk and must be ignored by the block.
	function automatic pay_beat_t cont_beat(input logic [7:0] payload);
		pay_beat_t b;
		b.payload_byte = payload;
		b.first_of_message = 1'b0;
		b.chunk_stream_id = 17'($urandom);
		b.message_length = 24'($urandom);
		b.type_id = 8'($urandom);
		b.message_stream_id = $urandom;
		b.timestamp = $urandom;
		b.extended_timestamp = $urandom;
		return b;
	endfunction

	function automatic pay_beat_t head_beat(input logic [16:0] csid,
		input logic [23:0] len, input logic [7:0] type_byte, input logic [31:0] msid,
		input logic [31:0] ts, input logic [31:0] ext, input logic [7:0] payload);
		pay_beat_t b;
		b.payload_byte = payload;
		b.first_of_message = 1'b1;
		b.chunk_stream_id = csid;
		b.message_length = len;
		b.type_id = type_byte;
		b.message_stream_id = msid;
		b.timestamp = ts;
		b.extended_timestamp = ext;
		return b;
	endfunction

	// Spread chunk stream ids over the one-, two- and three-byte header forms,
	// with some ids from the whole 17-bit field.
	function automatic logic [16:0] rand_csid();
		case ($urandom_range(0, 9))
			0, 1, 2: return 17'($urandom_range(2, 63));
			3, 4, 5: return 17'($urandom_range(64, 319));
			6, 7:    return 17'($urandom_range(320, 65599));
			default: return 17'($urandom);
		endcase
	endfunction

	// Half of the timestamps lie below saturation; the rest sit near it or above it.
	function automatic logic [31:0] rand_ts();
		case ($urandom_range(0, 7))
			0, 1, 2, 3: return $urandom_range(0, 32'h00FF_FFFE);
			4:          return $urandom_range(32'h00FF_FFFD, 32'h0100_0002);
			5:          return 32'hFFFF_FFFF;
			default:    return $urandom;
		endcase
	endfunction

	// Mostly short messages; a few cross chunk boundaries, a few are huge and
	// get cut short by the next message.
	function automatic logic [23:0] rand_len();
		case ($urandom_range(0, 9))
			7, 8:    return 24'($urandom_range(25, 200));
			9:       return 24'($urandom);
			default: return 24'($urandom_range(1, 24));
		endcase
	endfunction

	// Offer one pay beat, maybe after an idle gap, and hold it until taken.
	task automatic send_beat(input pay_beat_t b);
		if (jitter && $urandom_range(0, 4) == 0) begin
			pay_valid <= 1'b0;
			pay_data <= cont_beat(8'($urandom));
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pay_valid <= 1'b1;
		pay_data <= b;
		@(posedge clk);
		while (pay_stall)
			@(posedge clk);
	endtask

	// Drop valid, wait for every expected wire beat, then let any ignored
	// beat still in the pipe drain out.
	task automatic settle();
		pay_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_chunk_size(input logic [16:0] size);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OUT_CHUNK_SIZE, 2'b00};
		pwdata <= {15'($urandom), size};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_message(input logic [16:0] csid, input logic [23:0] len,
		input logic [31:0] ts, input int n_beats);
		pay_beat_t b;
		b = cont_beat(8'($urandom));
		b.first_of_message = 1'b1;
		b.chunk_stream_id = csid;
		b.message_length = len;
		b.timestamp = ts;
		send_beat(b);
		for (int i = 1; i < n_beats; i++)
			send_beat(cont_beat(8'($urandom)));
		items += n_beats;
		msg_left = (n_beats >= int'(len)) ? 0 : int'(len) - n_beats;
	endtask

	// Well-formed messages most of the time; some are cut short so the next
	// header lands mid-message.
	task automatic random_message();
		logic [23:0] len;
		int          n;
		len = rand_len();
		if (len > 24'd200)
			n = $urandom_range(1, 30);
		else if ($urandom_range(0, 4) == 0)
			n = $urandom_range(1, int'(len));
		else
			n = int'(len);
		send_message(rand_csid(), len, rand_ts(), n);
	endtask

	task automatic random_phase(input logic [16:0] size, input int quota,
		input bit long_hold);
		int stop;
		settle();
		write_chunk_size(size);
		if (long_hold)
			hold_long = 1'b1;
		stop = items + quota;
		while (items < stop) begin
			// stray bytes with no message open: the block drops them
			if (msg_left == 0 && $urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) send_beat(cont_beat(8'($urandom)));
			else
				random_message();
		end
	endtask

	initial begin : stimulus
		arst_n <= 1'b0;
		pay_valid <= 1'b0;
		pay_data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		drained <= 1'b0;
		jitter = 1'b1;
		hold_long = 1'b0;
		msg_left = 0;
		items = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset chunk size of 128.
		// A byte before any message: dropped.
		send_beat(cont_beat(8'hFF));
		// One-byte basic header at the lowest legal id, all-ones stream id.
		send_beat(head_beat(17'd2, 24'd3, 8'h00, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 8'h00));
		send_beat(cont_beat(8'hFF));
		send_beat(cont_beat(8'h5A));
		// Zero length, timestamp one below saturation; next byte is dropped.
		send_beat(head_beat(17'd63, 24'd0, 8'hFF, 32'h1234_5678, 32'h00FF_FFFE, 32'd0, 8'h81));
		send_beat(cont_beat(8'h42));
		// Two-byte form, timestamp exactly at saturation, longest length.
		send_beat(head_beat(17'd64, 24'hFF_FFFF, 8'h14, 32'd0, 32'h00FF_FFFF,
			32'hDEAD_BEEF, 8'h11));
		send_beat(cont_beat(8'h22));
		// New header mid-message: abandon the rest of the old one.
		send_beat(head_beat(17'd319, 24'd2, 8'h09, 32'h8000_0001, 32'hFFFF_FFFF, 32'd0, 8'h33));
		send_beat(cont_beat(8'h44));
		send_beat(head_beat(17'd320, 24'd1, 8'h08, 32'd1, 32'h0100_0000, 32'h5555_AAAA, 8'h55));
		send_beat(head_beat(17'd65599, 24'd1, 8'h12, 32'd2, 32'd0, 32'd0, 8'h66));
		// Ids 0 and 1 clash with the escape codes.
		send_beat(head_beat(17'd0, 24'd1, 8'h01, 32'd3, 32'd7, 32'd0, 8'h67));
		send_beat(head_beat(17'd1, 24'd1, 8'h02, 32'd4, 32'd8, 32'd0, 8'h68));
		// Id beyond the three-byte range; leave the message open.
		send_beat(head_beat(17'h1_FFFF, 24'd2, 8'h12, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h0102_0304, 8'h77));

		// Shrink the chunk mid-message: the next byte needs a fmt-3 header.
		settle();
		write_chunk_size(17'd1);
		send_beat(cont_beat(8'h88));
		send_beat(head_beat(17'd100, 24'd3, 8'h03, 32'd5, 32'd5, 32'd0, 8'h89));
		send_beat(cont_beat(8'h99));
		send_beat(cont_beat(8'hAA));

		// Chunk size zero behaves as one.
		settle();
		write_chunk_size(17'd0);
		send_beat(head_beat(17'd5, 24'd2, 8'h04, 32'd6, 32'd9, 32'd0, 8'hAB));
		send_beat(cont_beat(8'hBB));

		settle();
		write_chunk_size(17'h1_0000);
		send_beat(head_beat(17'd3, 24'd4, 8'h05, 32'd7, 32'h00FF_FFFF, 32'hCAFE_F00D, 8'hCC));
		send_beat(cont_beat(8'hDD));
		send_beat(cont_beat(8'hEE));
		send_beat(cont_beat(8'h01));
		msg_left = 0;

		// Random part, about 500 beats over several chunk sizes.
		random_phase(17'($urandom_range(2, 16)), 110, 1'b0);
		random_phase(17'h1_0000, 90, 1'b0);
		// Hold the wire side off while beats keep coming.
		random_phase(17'd1, 100, 1'b1);
		random_phase(17'($urandom_range(17, 300)), 100, 1'b0);
		// Last stretch runs flat out on both sides.
		settle();
		jitter = 1'b0;
		random_phase(CHUNK_SIZE_RST, 100, 1'b0);

		settle();
		drained <= 1'b1;
		repeat (2) @(posedge clk);
		if (fails == 0) begin
			$display("** rtmp_chunk_framer: PASSED **");
		end else begin
			$display("** rtmp_chunk_framer: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
rtl/rcf_pkg.sv
rtl/rcf_core.sv
rtl/rcf_run_buf.sv
rtl/rtmp_chunk_framer.sv
dv/rcf_frame_checker.sv
dv/tb_rtmp_chunk_framer.sv
